### design/dctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctt_pkg: shared types and constants of the delayed call timer table
// Slot record layout, command and status codes, controller states.
// ----------------------------------------------------------------------------
package dctt_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [3:0] OP_ONCE       = 4'd0;
  localparam logic [3:0] OP_REPEAT     = 4'd1;
  localparam logic [3:0] OP_CANCEL     = 4'd2;
  localparam logic [3:0] OP_QUERY      = 4'd3;
  localparam logic [3:0] OP_PAUSE      = 4'd4;
  localparam logic [3:0] OP_RESUME     = 4'd5;
  localparam logic [3:0] OP_RESTART    = 4'd6;
  localparam logic [3:0] OP_PAUSE_ALL  = 4'd7;
  localparam logic [3:0] OP_RESUME_ALL = 4'd8;
  localparam logic [3:0] OP_ENABLE     = 4'd9;
  localparam logic [3:0] OP_TICK       = 4'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCHED, S_RD, S_EX, S_DIV, S_WB, S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] due;
    logic [30:0] period;
    logic        repeats;
    logic        paused;
    logic [31:0] left;
    logic        follows;
  } slot_rec_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### design/dctt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctt_in_if: command channel of the timer table
// Valid/ready handshake with one command item as payload.
// ----------------------------------------------------------------------------
interface dctt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] handle;
  logic signed [31:0] delay;
  logic signed [31:0] rate;
  logic        follow_enable;
  logic        owner_enabled;
  logic [31:0] now;

  modport source (output valid, opcode, handle, delay, rate, follow_enable,
                  owner_enabled, now, input ready);
  modport sink   (input valid, opcode, handle, delay, rate, follow_enable,
                  owner_enabled, now, output ready);
endinterface

### design/dctt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctt_out_if: result channel of the timer table
// Valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface dctt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] handle_out;
  logic [1:0]  status;
  logic        fired;
  logic        last;

  modport source (output valid, handle_out, status, fired, last, input ready);
  modport sink   (input valid, handle_out, status, fired, last, output ready);
endinterface

### design/delayed_call_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_call_timer_table_unit: table of one-shot and repeating timers
// Slot records live in one synchronous memory; a sequencer walks the slots
// with read, modify and write back, and a bit-serial remainder unit moves
// repeating timers to their next period boundary.
//
//   channel   direction  payload
//   in_ch     sink       opcode, handle, delay, rate, follow_enable,
//                        owner_enabled, now
//   out_ch    source     handle_out, status, fired, last
//
// Schedule and unused opcodes do not walk the slots. Single-timer commands,
// bulk commands and tick walk the slots; each repeating timer with a nonzero
// period that fires on a tick passes through the remainder unit.
// Reset empties the table at once; handles restart at one.
// A stalled result channel holds the walk when a further fired timer is found.
// ----------------------------------------------------------------------------
module delayed_call_timer_table_unit (
  input  logic clk,
  input  logic rst_n,
  dctt_in_if.sink    in_ch,
  dctt_out_if.source out_ch
);
  import dctt_pkg::*;

  state_t state_r, state_nxt;

  slot_rec_t mem [SLOTS];
  slot_rec_t rd_data_r;
  logic      mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_rec_t mem_wd;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0] nh_r, nh_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [3:0]  op_r, op_nxt;
  logic [31:0] h_r, h_nxt, delay_r, delay_nxt, now_r, now_nxt;
  logic [30:0] rate_r, rate_nxt;
  logic        follow_r, follow_nxt, en_r, en_nxt;

  logic [31:0] res_h_r, res_h_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [31:0] pend_h_r, pend_h_nxt;

  logic        out_v_r, out_v_nxt;
  logic [31:0] out_h_r, out_h_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic        out_f_r, out_f_nxt, out_l_r, out_l_nxt;

  logic [31:0] dvd_r, dvd_nxt, rem_r, rem_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;

  slot_rec_t   rec, mod;
  logic        hit_valid, match, tick_due, need_div, out_busy, ex_stall, last_idx;
  logic        in_xfer, single_op, free_found;
  logic [31:0] remain, rem_shift, nd_base;
  logic [32:0] nd_sum;
  logic [IDX_W-1:0] free_idx;

  assign rec       = rd_data_r;
  assign hit_valid = valid_r[idx_r];
  assign last_idx  = (idx_r == IDX_W'(SLOTS - 1));
  assign remain    = (rec.due > now_r) ? rec.due - now_r : 32'd0;
  assign match     = hit_valid && (rec.handle == h_r) && (h_r != 32'd0);
  assign tick_due  = hit_valid && !rec.paused && (rec.due <= now_r) &&
                     (cnt_r < CNT_W'(MAX_RESULTS));
  assign need_div  = tick_due && rec.repeats && (rec.period != 31'd0);
  assign out_busy  = out_v_r && !out_ch.ready;
  assign ex_stall  = (op_r == OP_TICK) && tick_due && pend_v_r && out_busy;
  assign single_op = (op_r inside {[OP_CANCEL:OP_RESTART]});
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign rem_shift = {rem_r[30:0], dvd_r[31]};
  assign nd_base   = now_r - rem_r;
  assign nd_sum    = {1'b0, nd_base} + {2'b0, rec.period};

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_v_r;
  assign out_ch.handle_out = out_h_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.fired      = out_f_r;
  assign out_ch.last       = out_l_r;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // single-slot modification for the current command
  always_comb begin
    mod = rec;
    case (op_r)
      OP_PAUSE, OP_PAUSE_ALL: begin
        if (!rec.paused) begin
          mod.paused = 1'b1;
          mod.left   = remain;
        end
      end
      OP_RESUME, OP_RESUME_ALL: begin
        if (rec.paused) begin
          mod.paused = 1'b0;
          mod.due    = sat_add(now_r, rec.left);
          mod.left   = 32'd0;
        end
      end
      OP_ENABLE: begin
        if (rec.follows) begin
          if (en_r && rec.paused) begin
            mod.paused = 1'b0;
            mod.due    = sat_add(now_r, rec.left);
            mod.left   = 32'd0;
          end else if (!en_r && !rec.paused) begin
            mod.paused = 1'b1;
            mod.left   = remain;
          end
        end
      end
      OP_RESTART: begin
        mod.paused = 1'b0;
        mod.left   = 32'd0;
        mod.due    = sat_add(now_r, rec.paused ? rec.left : remain);
      end
      OP_TICK: begin
        mod.due = now_r;
      end
      default: mod = rec;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.opcode inside {OP_ONCE, OP_REPEAT}) state_nxt = S_SCHED;
          else if (in_ch.opcode inside {[OP_CANCEL:OP_TICK]}) state_nxt = S_RD;
          else state_nxt = S_FIN;
        end
      end
      S_SCHED: state_nxt = S_FIN;
      S_RD:    state_nxt = S_EX;
      S_EX: begin
        if (ex_stall) state_nxt = S_EX;
        else if (single_op && match) state_nxt = S_FIN;
        else if (op_r == OP_TICK && need_div) state_nxt = S_DIV;
        else if (last_idx) state_nxt = S_FIN;
        else state_nxt = S_RD;
      end
      S_DIV: if (dcnt_r == 5'd31) state_nxt = S_WB;
      S_WB:  state_nxt = last_idx ? S_FIN : S_RD;
      S_FIN: if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt  = valid_r;
    nh_nxt     = nh_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    h_nxt      = h_r;
    delay_nxt  = delay_r;
    rate_nxt   = rate_r;
    follow_nxt = follow_r;
    en_nxt     = en_r;
    now_nxt    = now_r;
    res_h_nxt  = res_h_r;
    res_st_nxt = res_st_r;
    pend_v_nxt = pend_v_r;
    pend_h_nxt = pend_h_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_h_nxt  = out_h_r;
    out_st_nxt = out_st_r;
    out_f_nxt  = out_f_r;
    out_l_nxt  = out_l_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    mem_we     = 1'b0;
    mem_wa     = idx_r;
    mem_wd     = mod;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_ch.opcode;
          h_nxt      = in_ch.handle;
          delay_nxt  = in_ch.delay[31] ? 32'd0 : in_ch.delay;
          rate_nxt   = in_ch.rate[31] ? 31'd0 : in_ch.rate[30:0];
          follow_nxt = in_ch.follow_enable;
          en_nxt     = in_ch.owner_enabled;
          now_nxt    = in_ch.now;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          res_h_nxt  = in_ch.handle;
          res_st_nxt = ST_NOTFOUND;
        end
      end
      S_SCHED: begin
        if (!free_found) begin
          res_h_nxt  = 32'd0;
          res_st_nxt = ST_FULL;
        end else begin
          mem_we         = 1'b1;
          mem_wa         = free_idx;
          mem_wd.handle  = nh_r;
          mem_wd.due     = sat_add(now_r, delay_r);
          mem_wd.repeats = (op_r == OP_REPEAT);
          mem_wd.period  = (op_r == OP_REPEAT) ? rate_r : 31'd0;
          mem_wd.follows = follow_r;
          mem_wd.paused  = follow_r && !en_r;
          mem_wd.left    = (follow_r && !en_r) ? sat_add(now_r, delay_r) - now_r : 32'd0;
          valid_nxt[free_idx] = 1'b1;
          nh_nxt     = (nh_r == 32'hFFFF_FFFF) ? 32'd1 : nh_r + 32'd1;
          res_h_nxt  = nh_r;
          res_st_nxt = ST_OK;
        end
      end
      S_EX: begin
        if (!ex_stall) begin
          if (!last_idx) idx_nxt = idx_r + IDX_W'(1);
          if (single_op) begin
            if (match) begin
              res_st_nxt = ST_OK;
              if (op_r == OP_CANCEL) valid_nxt[idx_r] = 1'b0;
              else mem_we = 1'b1;
            end
          end else if (op_r == OP_TICK) begin
            res_st_nxt = ST_OK;
            if (tick_due) begin
              if (pend_v_r) begin
                out_v_nxt  = 1'b1;
                out_h_nxt  = pend_h_r;
                out_st_nxt = ST_OK;
                out_f_nxt  = 1'b1;
                out_l_nxt  = 1'b0;
              end
              pend_v_nxt = 1'b1;
              pend_h_nxt = rec.handle;
              cnt_nxt    = cnt_r + CNT_W'(1);
              if (!rec.repeats) begin
                valid_nxt[idx_r] = 1'b0;
              end else if (need_div) begin
                idx_nxt  = idx_r;
                dvd_nxt  = now_r - rec.due;
                rem_nxt  = 32'd0;
                dcnt_nxt = 5'd0;
              end else begin
                mem_we = 1'b1;
              end
            end
          end else begin
            res_st_nxt = ST_OK;
            if (hit_valid) mem_we = 1'b1;
          end
        end
      end
      S_DIV: begin
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        rem_nxt  = (rem_shift >= {1'b0, rec.period}) ? rem_shift - {1'b0, rec.period}
                                                     : rem_shift;
        dcnt_nxt = dcnt_r + 5'd1;
      end
      S_WB: begin
        mem_we     = 1'b1;
        mem_wd.due = nd_sum[32] ? 32'hFFFF_FFFF : nd_sum[31:0];
        if (!last_idx) idx_nxt = idx_r + IDX_W'(1);
      end
      S_FIN: begin
        if (!out_busy) begin
          out_v_nxt = 1'b1;
          out_l_nxt = 1'b1;
          if (op_r == OP_TICK) begin
            out_h_nxt  = pend_v_r ? pend_h_r : 32'd0;
            out_st_nxt = pend_v_r ? ST_OK : ST_NONE;
            out_f_nxt  = pend_v_r;
          end else begin
            out_h_nxt  = res_h_r;
            out_st_nxt = res_st_r;
            out_f_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == S_RD) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      nh_r     <= 32'd1;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      cnt_r    <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      nh_r     <= nh_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    h_r      <= h_nxt;
    delay_r  <= delay_nxt;
    rate_r   <= rate_nxt;
    follow_r <= follow_nxt;
    en_r     <= en_nxt;
    now_r    <= now_nxt;
    res_h_r  <= res_h_nxt;
    res_st_r <= res_st_nxt;
    pend_h_r <= pend_h_nxt;
    out_h_r  <= out_h_nxt;
    out_st_r <= out_st_nxt;
    out_f_r  <= out_f_nxt;
    out_l_r  <= out_l_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
  end

endmodule

### verif/tb_delayed_call_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delayed_call_timer_table_unit: self-checking bench of the timer table
// Drives commands over the input channel and predicts every result with its
// own timer table model. Each result transfer is checked field by field
// against the oldest prediction. Runs a directed pass, then random traffic
// under three idle patterns with a long result hold-off.
// ----------------------------------------------------------------------------
module tb_delayed_call_timer_table_unit;
  import dctt_pkg::*;

  typedef struct {
    logic [3:0]         op;
    logic [31:0]        handle;
    logic signed [31:0] delay;
    logic signed [31:0] rate;
    logic               follow;
    logic               en;
    logic [31:0]        now;
  } timer_cmd_t;

  typedef struct {
    logic [31:0] handle;
    logic [1:0]  status;
    logic        fired;
    logic        last;
  } timer_res_t;

  class timer_scoreboard;
    bit          vld[SLOTS];
    logic [31:0] hnd[SLOTS];
    logic [31:0] due[SLOTS];
    logic [31:0] left[SLOTS];
    logic [30:0] per[SLOTS];
    bit          rep[SLOTS];
    bit          psd[SLOTS];
    bit          fol[SLOTS];
    logic [31:0] nxt;
    timer_res_t  expected_q[$];
    int          errors;

    function new();
      nxt = 1;
      errors = 0;
      foreach (vld[i]) vld[i] = 0;
    endfunction

    function void push(logic [31:0] h, logic [1:0] st, logic fi, logic la);
      timer_res_t r;
      r.handle = h; r.status = st; r.fired = fi; r.last = la;
      expected_q = {expected_q, r};
    endfunction

    function logic [31:0] sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function logic [31:0] remain(int i, logic [31:0] now);
      return (due[i] > now) ? due[i] - now : 32'd0;
    endfunction

    function void hold_slot(int i, logic [31:0] now);
      if (!psd[i]) begin
        psd[i] = 1;
        left[i] = remain(i, now);
      end
    endfunction

    function void run_slot(int i, logic [31:0] now);
      if (psd[i]) begin
        psd[i] = 0;
        due[i] = sat(now, left[i]);
        left[i] = 0;
      end
    endfunction

    function void note_command(timer_cmd_t c);
      int i;
      int hit;
      int k;
      logic [31:0] d;
      logic [31:0] rt;
      logic [31:0] rm;
      logic [63:0] steps;
      logic [63:0] nd;
      d = c.delay[31] ? 32'd0 : c.delay;
      rt = c.rate[31] ? 32'd0 : c.rate;
      hit = -1;
      if (c.op == OP_ONCE || c.op == OP_REPEAT) begin
        for (i = 0; i < SLOTS; i++) if (!vld[i] && hit < 0) hit = i;
        if (hit < 0) begin
          push(0, ST_FULL, 0, 1);
          return;
        end
        vld[hit] = 1;
        hnd[hit] = nxt;
        nxt = nxt + 1;
        if (nxt == 0) nxt = 1;
        due[hit] = sat(c.now, d);
        rep[hit] = (c.op == OP_REPEAT);
        per[hit] = (c.op == OP_REPEAT) ? rt[30:0] : 31'd0;
        fol[hit] = c.follow;
        psd[hit] = 0;
        left[hit] = 0;
        if (c.follow && !c.en) begin
          psd[hit] = 1;
          left[hit] = due[hit] - c.now;
        end
        push(hnd[hit], ST_OK, 0, 1);
      end else if (c.op >= OP_CANCEL && c.op <= OP_RESTART) begin
        if (c.handle != 0)
          for (i = 0; i < SLOTS; i++)
            if (hit < 0 && vld[i] && hnd[i] == c.handle) hit = i;
        if (hit < 0) begin
          push(c.handle, ST_NOTFOUND, 0, 1);
          return;
        end
        case (c.op)
          OP_CANCEL: vld[hit] = 0;
          OP_PAUSE:  hold_slot(hit, c.now);
          OP_RESUME: run_slot(hit, c.now);
          OP_RESTART: begin
            rm = psd[hit] ? left[hit] : remain(hit, c.now);
            psd[hit] = 0;
            left[hit] = 0;
            due[hit] = sat(c.now, rm);
          end
          default: ;
        endcase
        push(c.handle, ST_OK, 0, 1);
      end else if (c.op >= OP_PAUSE_ALL && c.op <= OP_ENABLE) begin
        for (i = 0; i < SLOTS; i++) begin
          if (!vld[i]) continue;
          if (c.op == OP_PAUSE_ALL) hold_slot(i, c.now);
          else if (c.op == OP_RESUME_ALL) run_slot(i, c.now);
          else if (fol[i]) begin
            if (c.en) run_slot(i, c.now);
            else hold_slot(i, c.now);
          end
        end
        push(c.handle, ST_OK, 0, 1);
      end else if (c.op == OP_TICK) begin
        k = 0;
        for (i = 0; i < SLOTS && k < MAX_RESULTS; i++) begin
          if (!vld[i] || psd[i] || due[i] > c.now) continue;
          push(hnd[i], ST_OK, 1, 0);
          k++;
          if (!rep[i]) vld[i] = 0;
          else if (per[i] == 0) due[i] = c.now;
          else begin
            steps = 64'(c.now - due[i]) / 64'(per[i]) + 64'd1;
            nd = 64'(due[i]) + steps * 64'(per[i]);
            due[i] = (nd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nd[31:0];
          end
        end
        if (k == 0) push(0, ST_NONE, 0, 1);
        else expected_q[$].last = 1;
      end else begin
        push(c.handle, ST_NOTFOUND, 0, 1);
      end
    endfunction

    function void check_result(timer_res_t r);
      timer_res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result handle_out=%0h status=%0d", r.handle, r.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.handle !== e.handle) begin
        $error("handle_out expected %0h actual %0h", e.handle, r.handle);
        errors++;
      end
      if (r.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, r.status);
        errors++;
      end
      if (r.fired !== e.fired) begin
        $error("fired expected %0d actual %0d", e.fired, r.fired);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  dctt_in_if  in_ch();
  dctt_out_if out_ch();

  delayed_call_timer_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  timer_scoreboard timers = new();
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;
  logic [31:0] clock_now;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.handle = '0;
    in_ch.delay = '0;
    in_ch.rate = '0;
    in_ch.follow_enable = 1'b0;
    in_ch.owner_enabled = 1'b0;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        timers.check_result('{out_ch.handle_out, out_ch.status, out_ch.fired, out_ch.last});
      if (hold_req && hold_left == 0) begin
        hold_req <= 1'b0;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_delayed_call_timer_table_unit: FAIL");
      $finish;
    end
  end

  task automatic send(logic [3:0] op, logic [31:0] h, logic [31:0] d, logic [31:0] r,
                      logic f, logic e, logic [31:0] n);
    timer_cmd_t c;
    c = '{op, h, d, r, f, e, n};
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.handle <= h;
    in_ch.delay <= d;
    in_ch.rate <= r;
    in_ch.follow_enable <= f;
    in_ch.owner_enabled <= e;
    in_ch.now <= n;
    do @(posedge clk); while (!in_ch.ready);
    timers.note_command(c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    int pick;
    logic [31:0] h;
    logic [31:0] d;
    logic [31:0] r;
    pick = $urandom_range(99);
    clock_now = clock_now + $urandom_range(0, 40);
    case ($urandom_range(9))
      0:       h = 0;
      1:       h = $urandom;
      default: h = timers.nxt - $urandom_range(1, 18);
    endcase
    case ($urandom_range(9))
      0:       d = $urandom;
      1:       d = -$urandom_range(1, 1000);
      default: d = $urandom_range(0, 80);
    endcase
    case ($urandom_range(9))
      0:       r = $urandom;
      1:       r = -$urandom_range(1, 1000);
      2:       r = 0;
      default: r = $urandom_range(1, 40);
    endcase
    if (pick < 36)
      send(4'($urandom_range(OP_ONCE, OP_REPEAT)), h, d, r, 1'($urandom_range(1)),
           $urandom_range(3) != 0, clock_now);
    else if (pick < 62)
      send(OP_TICK, h, d, r, 1'($urandom_range(1)), 1'($urandom_range(1)), clock_now);
    else if (pick < 88)
      send(4'($urandom_range(OP_CANCEL, OP_RESTART)), h, d, r, 1'($urandom_range(1)),
           1'($urandom_range(1)), clock_now);
    else if (pick < 97)
      send(4'($urandom_range(OP_PAUSE_ALL, OP_ENABLE)), h, d, r, 1'($urandom_range(1)),
           1'($urandom_range(1)), clock_now);
    else
      send(4'($urandom_range(11, 15)), h, d, r, 1'($urandom_range(1)),
           1'($urandom_range(1)), clock_now);
  endtask

  initial begin
    int i;
    send_idle_pct = 34;
    recv_idle_pct = 84;
    hold_req = 1'b0;
    clock_now = 32'd100;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_ONCE, 0, -32'sd5, 0, 0, 1, 100);
    send(OP_REPEAT, 0, 10, -32'sd3, 0, 1, 100);
    send(OP_ONCE, 0, 32'h7FFF_FFFF, 0, 0, 1, 32'hFFFF_FF00);
    send(OP_ONCE, 0, 20, 0, 1, 0, 100);
    send(OP_QUERY, 4, 0, 0, 0, 0, 100);
    send(OP_QUERY, 0, 0, 0, 0, 0, 100);
    send(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 100);
    send(OP_PAUSE, 2, 0, 0, 0, 0, 105);
    send(OP_RESUME, 2, 0, 0, 0, 0, 107);
    send(OP_RESTART, 4, 0, 0, 0, 0, 108);
    send(OP_PAUSE_ALL, 0, 0, 0, 0, 0, 109);
    send(OP_RESUME_ALL, 0, 0, 0, 0, 0, 110);
    send(OP_ENABLE, 0, 0, 0, 0, 0, 111);
    send(OP_ENABLE, 0, 0, 0, 0, 1, 112);
    send(OP_TICK, 0, 0, 0, 0, 0, 50);
    send(OP_TICK, 0, 0, 0, 0, 0, 150);
    send(4'd11, 7, 0, 0, 0, 0, 150);
    send(4'd15, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    send(OP_CANCEL, 3, 0, 0, 0, 0, 150);
    send(OP_REPEAT, 0, 3, 7, 1, 1, 150);
    for (i = 0; i < 17; i++)
      send(OP_ONCE, 0, 0, 0, 0, 1, 160);
    send(OP_TICK, 0, 0, 0, 0, 0, 200);
    send(OP_TICK, 0, 0, 0, 0, 0, 300);
    clock_now = 32'd300;

    repeat (24) send_random();
    send_idle_pct = 84;
    recv_idle_pct = 34;
    repeat (24) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (23) send_random();
    in_ch.valid <= 1'b0;

    while (timers.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (timers.errors == 0)
      $display("tb_delayed_call_timer_table_unit: PASS");
    else
      $display("tb_delayed_call_timer_table_unit: FAIL");
    $finish;
  end

endmodule
